### rtl/crc8_configurable_engine_assert.svh
// Assertion macros for the CRC-8 engine.
`ifndef CRC8_CONFIGURABLE_ENGINE_ASSERT_SVH
`define CRC8_CONFIGURABLE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define CE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crc8 engine assertion failed");

// Next-cycle implication, checked out of reset.
`define CE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crc8 engine assertion failed");

`else

`define CE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/crc8ce_pkg.sv
// Package: payload types, configuration types and constants of the CRC-8 engine.
`default_nettype none

package crc8ce_pkg;

	localparam int CRC_W = 8;

	localparam logic [CRC_W-1:0] POLY_RESET = 8'h31;
	localparam logic [CRC_W-1:0] INIT_RESET = 8'hFF;
	localparam logic [CRC_W-1:0] CRC_RESET  = 8'hFF;

	// Configuration register indexes
	localparam logic REG_POLYNOMIAL    = 1'b0;
	localparam logic REG_INITIAL_VALUE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [15:0] data_in;
		logic        first_item;
		logic        last_item;
	} item_t;

	typedef struct packed {
		logic [CRC_W-1:0] crc_value;
		logic             last_out;
	} result_t;

	typedef struct packed {
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] initial_value;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/crc8_configurable_engine.sv
// Top level of the streaming CRC-8 engine with configurable polynomial and seed.
//
// Channel   Dir  Handshake                 Payload
// item      in   item_valid / item_stall   crc8ce_pkg::item_t   (mode, data_in, flags)
// result    out  result_valid / result_stall crc8ce_pkg::result_t (crc_value, last_out)
// cfg       in   cfg_write (no wait)       cfg_index, cfg_data  (polynomial, initial_value)
//
// One item per cycle sustained while the result side does not stall. An item
// is captured in the input register at its transfer and folded into the
// result register once that register is free or drains; the 16-step XOR
// network and the running-CRC feedback lie between those two registers.
// Reset clears both valid flags, loads the registers to polynomial 0x31 and
// seed 0xFF, and sets the running CRC to 0xFF.
// A stall on the result side holds the result register; the input register
// then holds its item and stalls the item side in the same cycle.
`default_nettype none

`include "crc8_configurable_engine_assert.svh"

module crc8_configurable_engine (
	input  wire                         clk,
	input  wire                         arst_n,
	// Item channel
	input  wire                         item_valid,
	output logic                        item_stall,
	input  crc8ce_pkg::item_t           item,
	// Result channel
	output logic                        result_valid,
	input  wire                         result_stall,
	output crc8ce_pkg::result_t         result,
	// Configuration write port
	input  wire                         cfg_write,
	input  wire                         cfg_index,
	input  wire [crc8ce_pkg::CRC_W-1:0] cfg_data
);

	crc8ce_pkg::cfg_t    cfg;
	crc8ce_pkg::item_t   item_s1;
	logic                item_valid_s1;
	crc8ce_pkg::result_t fold_result;
	crc8ce_pkg::result_t result_q;
	logic                result_valid_q;
	logic [crc8ce_pkg::CRC_W-1:0] running_crc_q;
	logic                advance;

	crc8ce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crc8ce_fold u_fold (
		.item        (item_s1),
		.running_crc (running_crc_q),
		.cfg         (cfg),
		.result      (fold_result)
	);

	// Advance the input stage whenever the result register is free or drains now.
	assign advance    = item_valid_s1 && !(result_valid_q && result_stall);
	// Hold the item side only while a captured item cannot move on.
	assign item_stall = item_valid_s1 && !advance;

	// Input register: capture on transfer, drop the valid flag once folded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register and running CRC advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			running_crc_q  <= crc8ce_pkg::CRC_RESET;
		end else if (advance) begin
			result_valid_q <= 1'b1;
			running_crc_q  <= fold_result.crc_value;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= fold_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A stalled item side always has an item waiting in the input register.
	`CE_ASSERT_NOW(a_stall_has_item, clk, arst_n, item_stall, item_valid_s1)
	// A folded item shows up as a valid result on the next cycle.
	`CE_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, result_valid_q)
	// After each fold the running CRC matches the CRC value in the result register.
	`CE_ASSERT_NEXT(a_running_matches, clk, arst_n, advance, running_crc_q == result_q.crc_value)
	// A polynomial write lands in the register on the next cycle.
	`CE_ASSERT_NEXT(a_poly_write, clk, arst_n, cfg_write && cfg_index == crc8ce_pkg::REG_POLYNOMIAL, cfg.polynomial == $past(cfg_data))

endmodule

`default_nettype wire

### rtl/crc8ce_cfg.sv
// Configuration register file: polynomial and initial value.
`default_nettype none

module crc8ce_cfg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_write,
	input  wire                        cfg_index,
	input  wire [crc8ce_pkg::CRC_W-1:0] cfg_data,
	output crc8ce_pkg::cfg_t           cfg
);

	crc8ce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial    <= crc8ce_pkg::POLY_RESET;
			cfg_q.initial_value <= crc8ce_pkg::INIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				crc8ce_pkg::REG_POLYNOMIAL:    cfg_q.polynomial    <= cfg_data;
				crc8ce_pkg::REG_INITIAL_VALUE: cfg_q.initial_value <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/crc8ce_fold.sv
// Combinational CRC-8 fold of one item (one or two bytes, MSB first).
`default_nettype none

module crc8ce_fold (
	input  crc8ce_pkg::item_t           item,
	input  wire [crc8ce_pkg::CRC_W-1:0] running_crc,
	input  crc8ce_pkg::cfg_t            cfg,
	output crc8ce_pkg::result_t         result
);

	// Shift one byte through the generator, eight XOR steps.
	function automatic logic [crc8ce_pkg::CRC_W-1:0] fold_byte(
		input logic [crc8ce_pkg::CRC_W-1:0] acc,
		input logic [7:0]                   data,
		input logic [crc8ce_pkg::CRC_W-1:0] poly
	);
		logic [crc8ce_pkg::CRC_W-1:0] v;
		v = acc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (v[crc8ce_pkg::CRC_W-1])
				v = {v[crc8ce_pkg::CRC_W-2:0], 1'b0} ^ poly;
			else
				v = {v[crc8ce_pkg::CRC_W-2:0], 1'b0};
		end
		return v;
	endfunction

	logic [crc8ce_pkg::CRC_W-1:0] start_crc;
	logic [crc8ce_pkg::CRC_W-1:0] high_crc;
	logic [crc8ce_pkg::CRC_W-1:0] mid_crc;

	always_comb begin
		start_crc = item.first_item ? cfg.initial_value : running_crc;
		high_crc  = fold_byte(start_crc, item.data_in[15:8], cfg.polynomial);
		// Skip the high byte in single-byte mode
		mid_crc   = item.mode ? high_crc : start_crc;
		result.crc_value = fold_byte(mid_crc, item.data_in[7:0], cfg.polynomial);
		result.last_out  = item.last_item;
	end

endmodule

`default_nettype wire
